/* sv/bts_pkg.sv */
// Shared types and codes for the byte-table stream cipher unit.
package bts_pkg;

	localparam int unsigned TableDepth = 256;
	localparam int unsigned AddrW      = $clog2(TableDepth);
	localparam int unsigned LenW       = AddrW + 1;

	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_KEY   = 2'd1;
	localparam logic [1:0] FN_NONCE = 2'd2;
	localparam logic [1:0] FN_DATA  = 2'd3;

	localparam logic [1:0] CFG_KEY_LEN   = 2'd0;
	localparam logic [1:0] CFG_NONCE_LEN = 2'd1;

	localparam logic [LenW-1:0] KEY_LEN_RESET   = LenW'(32);
	localparam logic [LenW-1:0] NONCE_LEN_RESET = LenW'(16);
	localparam logic [LenW-1:0] LEN_MAX         = LenW'(TableDepth);

	typedef struct packed {
		logic             en;
		logic             we;
		logic [AddrW-1:0] addr;
		logic [7:0]       wdata;
	} mem_req_t;

endpackage

/* sv/bts_table.sv */
// Mixing table: single-port 256 x 8 memory, registered read, per-entry valid bits.
module bts_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  bts_pkg::mem_req_t   req,
	output logic [7:0]          rdata
);
	import bts_pkg::*;

	logic [7:0]            mem [TableDepth];
	logic [TableDepth-1:0] valid_q;
	logic [7:0]            rd_q;
	logic                  rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.en && req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.en && !req.we) begin
			rd_q <= mem[req.addr];
		end
	end

	// entries never written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (req.en && req.we) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.en && !req.we) begin
				rd_vld_q <= valid_q[req.addr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : 8'd0;

endmodule

/* sv/bts_ctrl.sv */
// Sequencer: loads, mixes and keystream steps as read-modify-write on the table.
module bts_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [1:0]              func,
	input  logic [7:0]              byte_value,
	input  logic [bts_pkg::LenW-1:0] eff_key,
	input  logic [bts_pkg::LenW-1:0] eff_nonce,
	input  logic [7:0]              rdata,
	output bts_pkg::mem_req_t       req,
	output logic                    clr,
	output logic                    busy,
	output logic                    done,
	output logic [7:0]              out_byte,
	output logic                    status
);
	import bts_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_NONCE, PH_DATA} phase_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LDWR,
		S_KM0, S_KM1, S_KM2,
		S_F2_0, S_F2_1, S_F2_2, S_F2_3, S_F2_4,
		S_F3_0, S_F3_1, S_F3_2, S_F3_3,
		S_D1, S_D2, S_D3, S_D4, S_D5
	} state_t;

	state_t            state_q;
	phase_t            ph_q;
	logic [7:0]        walk_q;
	logic [7:0]        dpos_q;
	logic [LenW-1:0]   kcnt_q;
	logic [LenW-1:0]   ncnt_q;
	logic [AddrW-1:0]  cnt_q;
	logic [AddrW-1:0]  kmod_q;
	logic [7:0]        a_q;
	logic [7:0]        b_q;
	logic              fin_q;
	logic              done_q;
	logic [7:0]        out_q;
	logic              status_q;

	logic              acc;
	logic              key_ok;
	logic              nonce_ok;
	logic              data_ok;
	logic [LenW-1:0]   rest;
	logic [AddrW-1:0]  ld_addr;
	logic [7:0]        ld_sum;
	logic [LenW-1:0]   kcnt_nx;
	logic [LenW-1:0]   ncnt_nx;
	logic [LenW-1:0]   cnt_inc;
	logic [AddrW-1:0]  f2_next;
	logic [LenW-1:0]   kmod_inc;

	assign acc      = start && (state_q == S_IDLE);
	assign key_ok   = (func == FN_KEY) && (ph_q == PH_KEY);
	assign nonce_ok = (func == FN_NONCE) && (ph_q == PH_NONCE);
	assign data_ok  = (func == FN_DATA) && (ph_q == PH_DATA);
	assign clr      = acc && (func == FN_START);
	assign busy     = (state_q != S_IDLE);

	assign rest     = LEN_MAX - eff_key;
	assign ld_addr  = (ph_q == PH_KEY) ? kcnt_q[AddrW-1:0] : ncnt_q[AddrW-1:0];
	assign ld_sum   = rdata + b_q;
	assign kcnt_nx  = kcnt_q + LenW'(1);
	assign ncnt_nx  = ncnt_q + LenW'(1);
	assign cnt_inc  = {1'b0, cnt_q} + LenW'(1);
	assign kmod_inc = {1'b0, kmod_q} + LenW'(1);
	// (c + 1) mod rest
	assign f2_next  = (cnt_inc == rest) ? '0 : cnt_inc[AddrW-1:0];

	always_comb begin
		req = '0;
		case (state_q)
			S_IDLE: begin
				if (acc && key_ok) begin
					req.en   = 1'b1;
					req.addr = kcnt_q[AddrW-1:0];
				end else if (acc && nonce_ok) begin
					req.en   = 1'b1;
					req.addr = ncnt_q[AddrW-1:0];
				end else if (acc && data_ok) begin
					req.en   = 1'b1;
					req.addr = walk_q;
				end
			end
			S_LDWR: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.addr  = ld_addr;
				req.wdata = ld_sum;
			end
			S_KM0: begin
				req.en   = 1'b1;
				req.addr = kmod_q;
			end
			S_KM1: begin
				req.en   = 1'b1;
				req.addr = walk_q;
			end
			S_KM2: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.addr  = walk_q;
				req.wdata = a_q + rdata;
			end
			S_F2_0: begin
				req.en   = 1'b1;
				req.addr = cnt_q;
			end
			S_F2_1: begin
				req.en   = 1'b1;
				req.addr = f2_next;
			end
			S_F2_2: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.addr  = cnt_q + eff_key[AddrW-1:0];
				req.wdata = a_q + rdata + walk_q;
			end
			S_F2_3: begin
				req.en   = 1'b1;
				req.addr = walk_q;
			end
			S_F3_0: begin
				req.en   = 1'b1;
				req.addr = cnt_q;
			end
			S_F3_1: begin
				req.en   = 1'b1;
				req.addr = {~cnt_q[AddrW-1], cnt_q[AddrW-2:0]};
			end
			S_F3_2: begin
				req.en   = 1'b1;
				req.addr = walk_q;
			end
			S_F3_3: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.addr  = cnt_q;
				req.wdata = a_q + rdata;
			end
			S_D1: begin
				req.en   = 1'b1;
				req.addr = dpos_q;
			end
			S_D2: begin
				req.en   = 1'b1;
				req.addr = walk_q;
			end
			S_D3: begin
				req.en    = 1'b1;
				req.we    = 1'b1;
				req.addr  = walk_q;
				req.wdata = a_q + rdata;
			end
			S_D4: begin
				req.en   = 1'b1;
				req.addr = a_q;
			end
			default: req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ph_q     <= PH_IDLE;
			walk_q   <= '0;
			dpos_q   <= '0;
			kcnt_q   <= '0;
			ncnt_q   <= '0;
			cnt_q    <= '0;
			kmod_q   <= '0;
			a_q      <= '0;
			b_q      <= '0;
			fin_q    <= 1'b0;
			done_q   <= 1'b0;
			out_q    <= '0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						b_q <= byte_value;
						if (func == FN_START) begin
							ph_q   <= PH_KEY;
							walk_q <= '0;
							dpos_q <= '0;
							kcnt_q <= '0;
							ncnt_q <= '0;
						end else if (key_ok || nonce_ok) begin
							state_q <= S_LDWR;
						end else if (data_ok) begin
							state_q <= S_D1;
						end else begin
							// wrong phase: dropped, reported without leaving idle
							done_q   <= 1'b1;
							out_q    <= '0;
							status_q <= 1'b1;
						end
					end
				end
				S_LDWR: begin
					state_q <= S_IDLE;
					cnt_q   <= '0;
					kmod_q  <= '0;
					if (ph_q == PH_KEY) begin
						walk_q <= walk_q + ld_sum + kcnt_q[AddrW-1:0];
						kcnt_q <= kcnt_nx;
						if (kcnt_nx >= eff_key) begin
							fin_q   <= 1'b0;
							state_q <= S_KM0;
						end
					end else begin
						walk_q <= walk_q + ld_sum;
						ncnt_q <= ncnt_nx;
						if (ncnt_nx >= eff_nonce) begin
							fin_q   <= 1'b1;
							state_q <= S_KM0;
						end
					end
				end
				S_KM0: state_q <= S_KM1;
				S_KM1: begin
					a_q     <= rdata;
					state_q <= S_KM2;
				end
				S_KM2: begin
					walk_q <= a_q + rdata;
					cnt_q  <= cnt_inc[AddrW-1:0];
					if (cnt_inc == LEN_MAX) begin
						kmod_q <= '0;
						if (fin_q) begin
							state_q <= (rest == '0) ? S_F3_0 : S_F2_0;
						end else if (eff_nonce == '0) begin
							// no nonce: the final mix opens with a second key mix
							fin_q   <= 1'b1;
							state_q <= S_KM0;
						end else begin
							ph_q    <= PH_NONCE;
							state_q <= S_IDLE;
						end
					end else begin
						kmod_q  <= (kmod_inc == eff_key) ? '0 : kmod_inc[AddrW-1:0];
						state_q <= S_KM0;
					end
				end
				S_F2_0: state_q <= S_F2_1;
				S_F2_1: begin
					a_q     <= rdata;
					state_q <= S_F2_2;
				end
				S_F2_2: state_q <= S_F2_3;
				S_F2_3: state_q <= S_F2_4;
				S_F2_4: begin
					walk_q <= rdata + a_q;
					if (cnt_inc == rest) begin
						cnt_q   <= '0;
						state_q <= S_F3_0;
					end else begin
						cnt_q   <= cnt_inc[AddrW-1:0];
						state_q <= S_F2_0;
					end
				end
				S_F3_0: state_q <= S_F3_1;
				S_F3_1: begin
					a_q     <= rdata;
					state_q <= S_F3_2;
				end
				S_F3_2: begin
					a_q     <= a_q + rdata;
					state_q <= S_F3_3;
				end
				S_F3_3: begin
					walk_q <= walk_q + a_q + rdata;
					cnt_q  <= cnt_inc[AddrW-1:0];
					if (cnt_inc == LEN_MAX) begin
						ph_q    <= PH_DATA;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_F3_0;
					end
				end
				S_D1: begin
					walk_q  <= rdata;
					state_q <= S_D2;
				end
				S_D2: begin
					a_q     <= rdata;
					state_q <= S_D3;
				end
				S_D3: begin
					a_q     <= a_q + rdata;
					state_q <= S_D4;
				end
				S_D4: state_q <= S_D5;
				S_D5: begin
					done_q   <= 1'b1;
					out_q    <= b_q ^ (rdata + a_q);
					status_q <= 1'b0;
					dpos_q   <= dpos_q + 8'd1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign out_byte = out_q;
	assign status   = status_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequence in progress");

	a_no_write_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr |-> !(req.en && req.we))
		else $error("table write coincides with clear");

	a_data_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && data_ok) |-> ##6 (done_q && !status_q))
		else $error("data item result missing");

	a_drop_report: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (func != FN_START) && !key_ok && !nonce_ok && !data_ok)
		|=> (done_q && status_q && (out_q == 8'd0)))
		else $error("dropped item not reported");

	a_data_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((ph_q == PH_DATA) && !clr) |=> (ph_q == PH_DATA))
		else $error("data phase left without start");
`endif

endmodule

/* sv/byte_table_stream_cipher_unit.sv */
// Byte-table stream cipher unit: configuration registers, sequencer and table.
//
// One item is taken when start is high and busy low; its result, if any, is marked
// by done on out_byte/status for a single cycle and cannot be held off. All work
// goes through one single-port 256-entry table as a run of reads and writes. A
// start clears the table; a key or nonce byte is added into its entry; a data byte
// gives its result in the same cycle that busy falls; an item out of phase is
// reported with status 1 in the next cycle. The key byte that completes the key
// adds a key mix over the whole table; the last nonce byte (or the last key byte
// when the nonce length is 0) adds the final mix: a second key mix, a pass over the
// first 256 - K entries and one over all 256, with K the key length clamped to
// 1..256. Configuration writes are always accepted and must be made while idle.
module byte_table_stream_cipher_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               func,
	input  logic [7:0]               byte_value,
	output logic                     done,
	output logic [7:0]               out_byte,
	output logic                     status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [bts_pkg::LenW-1:0] cfg_data
);
	import bts_pkg::*;

	logic [LenW-1:0] key_len_q;
	logic [LenW-1:0] nonce_len_q;
	logic [LenW-1:0] eff_key;
	logic [LenW-1:0] eff_nonce;
	mem_req_t        req;
	logic            clr;
	logic [7:0]      rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q   <= KEY_LEN_RESET;
			nonce_len_q <= NONCE_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KEY_LEN:   key_len_q   <= cfg_data;
				CFG_NONCE_LEN: nonce_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero key length acts as 1, lengths past the table size act as the table size
	assign eff_key   = (key_len_q == '0) ? LenW'(1) :
	                   (key_len_q > LEN_MAX) ? LEN_MAX : key_len_q;
	assign eff_nonce = (nonce_len_q > LEN_MAX) ? LEN_MAX : nonce_len_q;

	bts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.byte_value (byte_value),
		.eff_key    (eff_key),
		.eff_nonce  (eff_nonce),
		.rdata      (rdata),
		.req        (req),
		.clr        (clr),
		.busy       (busy),
		.done       (done),
		.out_byte   (out_byte),
		.status     (status)
	);

	bts_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.req    (req),
		.rdata  (rdata)
	);

endmodule
